FILE: rtl/core/cjmac_pkg.sv
package cjmac_pkg;

    // Number of lane operand pairs that one item carries.
    localparam int HW_LANES = 4;

    // Accumulator and result width, and the saturation point 2^SAT_EXP.
    localparam int ACC_BITS = 43;
    localparam int SAT_EXP  = 41;

    // Defaults for the top-level parameters.
    localparam int LANES_DEF       = 4;
    localparam int SAMPLE_BITS_DEF = 16;

    typedef logic signed [ACC_BITS-1:0] t_acc;

    // Per-item controls that the top level hands to every lane.
    typedef struct packed {
        logic s1_load;   // capture new products
        logic acc_fire;  // fold the captured products into the accumulators
        logic acc_clear; // the folded term was the last one: restart from zero
    } t_lane_ctrl;

endpackage

FILE: rtl/core/cjmac_lane.sv
module cjmac_lane #(
    parameter int SAMPLE_BITS = cjmac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cjmac_pkg::t_lane_ctrl         i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_a_re,
    input  logic signed [SAMPLE_BITS-1:0] i_a_im,
    input  logic signed [SAMPLE_BITS-1:0] i_b_re,
    input  logic signed [SAMPLE_BITS-1:0] i_b_im,
    output cjmac_pkg::t_acc               o_sum_re,
    output cjmac_pkg::t_acc               o_sum_im
);

    localparam int PW  = 2 * SAMPLE_BITS;
    localparam int ACC = cjmac_pkg::ACC_BITS;
    localparam int SW  = ((PW + 1) > ACC) ? (PW + 3) : (ACC + 2);

    localparam logic signed [SW-1:0] SAT_POS = SW'(64'sd1 <<< cjmac_pkg::SAT_EXP);
    localparam logic signed [SW-1:0] SAT_NEG = -SAT_POS;

    // Registered products of the current term.
    logic signed [PW-1:0] r_p_rr;
    logic signed [PW-1:0] r_p_ii;
    logic signed [PW-1:0] r_p_ir;
    logic signed [PW-1:0] r_p_ri;

    cjmac_pkg::t_acc r_acc_re;
    cjmac_pkg::t_acc r_acc_im;
    cjmac_pkg::t_acc n_acc_re;
    cjmac_pkg::t_acc n_acc_im;

    logic signed [SW-1:0] w_raw_re;
    logic signed [SW-1:0] w_raw_im;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.s1_load) begin
            r_p_rr <= i_a_re * i_b_re;
            r_p_ii <= i_a_im * i_b_im;
            r_p_ir <= i_a_im * i_b_re;
            r_p_ri <= i_a_re * i_b_im;
        end
    end

    // Exact sum of the old accumulator and both products, then one clamp.
    always_comb begin
        w_raw_re = SW'(r_acc_re) + SW'(r_p_rr) + SW'(r_p_ii);
        w_raw_im = SW'(r_acc_im) + SW'(r_p_ir) - SW'(r_p_ri);

        if (w_raw_re > SAT_POS) begin
            n_acc_re = ACC'(SAT_POS);
        end else if (w_raw_re < SAT_NEG) begin
            n_acc_re = ACC'(SAT_NEG);
        end else begin
            n_acc_re = w_raw_re[ACC-1:0];
        end

        if (w_raw_im > SAT_POS) begin
            n_acc_im = ACC'(SAT_POS);
        end else if (w_raw_im < SAT_NEG) begin
            n_acc_im = ACC'(SAT_NEG);
        end else begin
            n_acc_im = w_raw_im[ACC-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (i_ctrl.acc_fire) begin
            r_acc_re <= i_ctrl.acc_clear ? '0 : n_acc_re;
            r_acc_im <= i_ctrl.acc_clear ? '0 : n_acc_im;
        end
    end

    assign o_sum_re = n_acc_re;
    assign o_sum_im = n_acc_im;

endmodule

FILE: rtl/core/cjmac_merge.sv
module cjmac_merge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_stall,
    input  cjmac_pkg::t_acc i_sum_re [cjmac_pkg::HW_LANES],
    input  cjmac_pkg::t_acc i_sum_im [cjmac_pkg::HW_LANES],
    output logic            o_valid,
    output cjmac_pkg::t_acc o_c_re   [cjmac_pkg::HW_LANES],
    output cjmac_pkg::t_acc o_c_im   [cjmac_pkg::HW_LANES]
);

    logic            r_valid;
    logic            n_valid;
    cjmac_pkg::t_acc r_c_re [cjmac_pkg::HW_LANES];
    cjmac_pkg::t_acc r_c_im [cjmac_pkg::HW_LANES];

    // The loader only fires when this register is empty or being drained.
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_c_re <= i_sum_re;
            r_c_im <= i_sum_im;
        end
    end

    assign o_valid = r_valid;
    assign o_c_re  = r_c_re;
    assign o_c_im  = r_c_im;

endmodule

FILE: rtl/core/complex_conj_gram_mac_lanes_unit.sv
// A last term is registered with its products; its result is loaded into the
// output register once it is free. Throughput: one item per cycle; the input
// stalls only when a last term reaches the accumulators while the previous
// result is still held in the output register. Reset (synchronous, active low)
// empties the product stage and output register and zeroes all accumulators.
module complex_conj_gram_mac_lanes_unit #(
    parameter int LANES       = cjmac_pkg::LANES_DEF,
    parameter int SAMPLE_BITS = cjmac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_a_re,
    input  logic signed [SAMPLE_BITS-1:0] i_a_im,
    input  logic signed [SAMPLE_BITS-1:0] i_b0_re,
    input  logic signed [SAMPLE_BITS-1:0] i_b0_im,
    input  logic signed [SAMPLE_BITS-1:0] i_b1_re,
    input  logic signed [SAMPLE_BITS-1:0] i_b1_im,
    input  logic signed [SAMPLE_BITS-1:0] i_b2_re,
    input  logic signed [SAMPLE_BITS-1:0] i_b2_im,
    input  logic signed [SAMPLE_BITS-1:0] i_b3_re,
    input  logic signed [SAMPLE_BITS-1:0] i_b3_im,
    input  logic                          i_last_term,
    output logic                          o_valid,
    input  logic                          i_stall,
    output cjmac_pkg::t_acc               o_c0_re,
    output cjmac_pkg::t_acc               o_c0_im,
    output cjmac_pkg::t_acc               o_c1_re,
    output cjmac_pkg::t_acc               o_c1_im,
    output cjmac_pkg::t_acc               o_c2_re,
    output cjmac_pkg::t_acc               o_c2_im,
    output cjmac_pkg::t_acc               o_c3_re,
    output cjmac_pkg::t_acc               o_c3_im
);

    // Each lane computes a * conj(b) for its own operand pair. The four products of
    // a lane are registered in the first stage; the second stage adds them to the
    // lane's real and imaginary accumulators exactly and clamps the sum once to
    // +-2^41. The merge stage gathers every lane's sums into one output register,
    // and lanes beyond the configured count deliver zero.

    localparam int HW  = cjmac_pkg::HW_LANES;
    // At most as many lanes exist as there are operand pairs in an item.
    localparam int ACT = (LANES < HW) ? LANES : HW;

    logic signed [SAMPLE_BITS-1:0] w_b_re [HW];
    logic signed [SAMPLE_BITS-1:0] w_b_im [HW];

    cjmac_pkg::t_acc w_sum_re [HW];
    cjmac_pkg::t_acc w_sum_im [HW];
    cjmac_pkg::t_acc w_c_re   [HW];
    cjmac_pkg::t_acc w_c_im   [HW];

    // Product stage occupancy; the last flag travels alongside the products.
    logic r_s1_valid;
    logic n_s1_valid;
    logic r_s1_last;

    logic                  w_out_valid;
    logic                  w_out_free;
    logic                  w_acc_block;
    cjmac_pkg::t_lane_ctrl w_ctrl;

    assign w_b_re[0] = i_b0_re;
    assign w_b_im[0] = i_b0_im;
    assign w_b_re[1] = i_b1_re;
    assign w_b_im[1] = i_b1_im;
    assign w_b_re[2] = i_b2_re;
    assign w_b_im[2] = i_b2_im;
    assign w_b_re[3] = i_b3_re;
    assign w_b_im[3] = i_b3_im;

    // A term that is not last never waits on the output side, so the
    // accumulators only hold back when a finished result cannot yet be placed.
    assign w_out_free  = !w_out_valid || !i_stall;
    assign w_acc_block = r_s1_valid && r_s1_last && !w_out_free;

    always_comb begin
        w_ctrl.s1_load   = i_valid && !w_acc_block;
        w_ctrl.acc_fire  = r_s1_valid && !w_acc_block;
        w_ctrl.acc_clear = r_s1_last;

        if (w_ctrl.s1_load) begin
            n_s1_valid = 1'b1;
        end else if (w_ctrl.acc_fire) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.s1_load) begin
            r_s1_last <= i_last_term;
        end
    end

    assign o_stall = w_acc_block;

    for (genvar k = 0; k < HW; k++) begin : g_lane
        if (k < ACT) begin : g_active
            cjmac_lane #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_a_re  (i_a_re),
                .i_a_im  (i_a_im),
                .i_b_re  (w_b_re[k]),
                .i_b_im  (w_b_im[k]),
                .o_sum_re(w_sum_re[k]),
                .o_sum_im(w_sum_im[k])
            );
        end else begin : g_idle
            // A lane that is not configured reports zero sums.
            assign w_sum_re[k] = '0;
            assign w_sum_im[k] = '0;
        end
    end

    cjmac_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_ctrl.acc_fire && r_s1_last),
        .i_stall (i_stall),
        .i_sum_re(w_sum_re),
        .i_sum_im(w_sum_im),
        .o_valid (w_out_valid),
        .o_c_re  (w_c_re),
        .o_c_im  (w_c_im)
    );

    assign o_valid = w_out_valid;
    assign o_c0_re = w_c_re[0];
    assign o_c0_im = w_c_im[0];
    assign o_c1_re = w_c_re[1];
    assign o_c1_im = w_c_im[1];
    assign o_c2_re = w_c_re[2];
    assign o_c2_im = w_c_im[2];
    assign o_c3_re = w_c_re[3];
    assign o_c3_im = w_c_im[3];

endmodule

FILE: rtl/core/cjmac_checker.sv
module cjmac_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            i_last_term,
    input logic            o_valid,
    input logic            i_stall,
    input cjmac_pkg::t_acc o_c0_re,
    input cjmac_pkg::t_acc o_c3_im
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The input is only held back by a result that is waiting to be taken.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // A clear-path last term yields a result after the product and output registers.
    a_last_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_term) ##1 !o_stall |=> o_valid)
        else $error("result missing after an accepted last term");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_c0_re) && $stable(o_c3_im)))
        else $error("stalled result changed");

endmodule

bind complex_conj_gram_mac_lanes_unit cjmac_checker u_cjmac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_last_term(i_last_term),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_c0_re    (o_c0_re),
    .o_c3_im    (o_c3_im)
);
